[rtl/mcfc_pkg.sv]
`timescale 1ns / 1ps

package mcfc_pkg;

  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  SIGN_BYTE    = 8'h7F;
  localparam logic [7:0]  ACK_BYTE     = 8'hFF;
  localparam logic [7:0]  MIN_LENGTH   = 8'd8;
  localparam logic [7:0]  STATION_INIT = 8'd1;

  localparam logic [7:0] POS_ADDR = 8'd0;
  localparam logic [7:0] POS_SIGN = 8'd1;
  localparam logic [7:0] POS_LEN  = 8'd2;
  localparam logic [7:0] POS_SEQ  = 8'd3;
  localparam logic [7:0] POS_CMD  = 8'd4;
  localparam logic [7:0] POS_ACK  = 8'd5;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_CRC  = 3'd1,
    ST_ACK  = 3'd2,
    ST_SIGN = 3'd3,
    ST_ADDR = 3'd4,
    ST_LEN  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_length;
    logic [15:0] computed_crc;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mcfc_in_reg.sv]
`timescale 1ns / 1ps

module mcfc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcfc_pkg::in_beat_t in_beat,
  input  logic              take,
  output logic              beat_valid,
  output mcfc_pkg::in_beat_t beat
);

  logic               valid_r;
  logic               valid_nxt;
  mcfc_pkg::in_beat_t beat_r;
  logic               accept;

  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign valid_nxt  = accept || (valid_r && !take);
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= in_beat;
    end
  end

endmodule

[rtl/mcfc_frame.sv]
`timescale 1ns / 1ps

module mcfc_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mcfc_pkg::in_beat_t beat,
  input  logic [7:0]         station_address,
  output logic               res_valid,
  output mcfc_pkg::result_t  res
);

  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  byte_position_r, byte_position_nxt;
  logic [7:0]  length_seen_r, length_seen_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  header_address_r, header_address_nxt;
  logic [7:0]  header_sign_r, header_sign_nxt;
  logic [7:0]  header_ack_r, header_ack_nxt;
  logic [7:0]  header_command_r, header_command_nxt;
  logic [7:0]  header_sequence_r, header_sequence_nxt;
  logic [7:0]  trailer_low_r, trailer_low_nxt;

  logic        active;
  logic [7:0]  pos;
  logic [15:0] crc_cur;
  logic [8:0]  pos_p1, pos_p2, len_w;
  logic        short_len, last_byte, do_crc, take_trailer;
  logic [15:0] trailer;
  mcfc_pkg::status_t status;

  always_comb begin
    active  = beat.frame_start || in_frame_r;
    pos     = beat.frame_start ? 8'd0 : byte_position_r;
    crc_cur = beat.frame_start ? mcfc_pkg::CRC_INIT : running_crc_r;

    header_address_nxt  = (pos == mcfc_pkg::POS_ADDR) ? beat.data_byte : header_address_r;
    header_sign_nxt     = (pos == mcfc_pkg::POS_SIGN) ? beat.data_byte : header_sign_r;
    length_seen_nxt     = (pos == mcfc_pkg::POS_LEN)  ? beat.data_byte : length_seen_r;
    header_sequence_nxt = (pos == mcfc_pkg::POS_SEQ)  ? beat.data_byte : header_sequence_r;
    header_command_nxt  = (pos == mcfc_pkg::POS_CMD)  ? beat.data_byte : header_command_r;
    header_ack_nxt      = (pos == mcfc_pkg::POS_ACK)  ? beat.data_byte : header_ack_r;

    pos_p1 = {1'b0, pos} + 9'd1;
    pos_p2 = {1'b0, pos} + 9'd2;
    len_w  = {1'b0, length_seen_nxt};

    short_len    = (pos == mcfc_pkg::POS_LEN) && (length_seen_nxt < mcfc_pkg::MIN_LENGTH);
    do_crc       = (pos < mcfc_pkg::POS_LEN) || (pos_p2 < len_w);
    take_trailer = (pos >= mcfc_pkg::POS_LEN) && (pos_p2 == len_w);
    last_byte    = !short_len && (pos >= mcfc_pkg::POS_LEN) && (pos_p1 == len_w);

    running_crc_nxt   = do_crc ? mcfc_pkg::crc_byte(crc_cur, beat.data_byte) : crc_cur;
    trailer_low_nxt   = take_trailer ? beat.data_byte : trailer_low_r;
    byte_position_nxt = pos_p1[7:0];
    in_frame_nxt      = !(short_len || last_byte);
    trailer           = {beat.data_byte, trailer_low_r};
  end

  // priority: address, sign, then length or ack and crc
  always_comb begin
    if (header_address_nxt != station_address) begin
      status = mcfc_pkg::ST_ADDR;
    end else if (header_sign_nxt != mcfc_pkg::SIGN_BYTE) begin
      status = mcfc_pkg::ST_SIGN;
    end else if (short_len) begin
      status = mcfc_pkg::ST_LEN;
    end else if (header_ack_nxt != mcfc_pkg::ACK_BYTE) begin
      status = mcfc_pkg::ST_ACK;
    end else if (running_crc_nxt != trailer) begin
      status = mcfc_pkg::ST_CRC;
    end else begin
      status = mcfc_pkg::ST_OK;
    end
  end

  always_comb begin
    res_valid        = active && (short_len || last_byte);
    res.status       = status;
    res.frame_length = length_seen_nxt;
    if (short_len) begin
      res.command      = 8'd0;
      res.sequence_res = 8'd0;
      res.computed_crc = 16'd0;
    end else begin
      res.command      = header_command_nxt;
      res.sequence_res = header_sequence_nxt;
      res.computed_crc = running_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r        <= 1'b0;
      byte_position_r   <= 8'd0;
      length_seen_r     <= 8'd0;
      running_crc_r     <= mcfc_pkg::CRC_INIT;
      header_address_r  <= 8'd0;
      header_sign_r     <= 8'd0;
      header_ack_r      <= 8'd0;
      header_command_r  <= 8'd0;
      header_sequence_r <= 8'd0;
      trailer_low_r     <= 8'd0;
    end else if (fire && active) begin
      in_frame_r        <= in_frame_nxt;
      byte_position_r   <= byte_position_nxt;
      length_seen_r     <= length_seen_nxt;
      running_crc_r     <= running_crc_nxt;
      header_address_r  <= header_address_nxt;
      header_sign_r     <= header_sign_nxt;
      header_ack_r      <= header_ack_nxt;
      header_command_r  <= header_command_nxt;
      header_sequence_r <= header_sequence_nxt;
      trailer_low_r     <= trailer_low_nxt;
    end
  end

endmodule

[rtl/mcfc_out_reg.sv]
`timescale 1ns / 1ps

module mcfc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mcfc_pkg::result_t res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_stall,
  output mcfc_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  mcfc_pkg::result_t res_r;

  assign slot_free = !valid_r || !out_stall;
  assign valid_nxt = slot_free ? load : valid_r;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      res_r <= res;
    end
  end

endmodule

[rtl/modbus_crc_frame_checker.sv]
`timescale 1ns / 1ps
// out_valid rises once the final beat's result is loaded into the result register
// throughput: 1 byte per cycle, set by the byte-wise crc update between the input
// and result registers; a stalled result beat holds the input register and in_stall
// reset: synchronous active low, clears frame state, crc to 0xffff, station address to 1
// no result is produced until a beat with frame_start arrives

module modbus_crc_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_command,
  output logic [7:0]  out_sequence_res,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_computed_crc
);

  logic [7:0]         station_address_r;
  mcfc_pkg::in_beat_t in_beat;
  mcfc_pkg::in_beat_t beat;
  logic               beat_valid;
  logic               slot_free;
  logic               fire;
  logic               res_valid;
  mcfc_pkg::result_t  res;
  mcfc_pkg::result_t  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_address_r <= mcfc_pkg::STATION_INIT;
    end else if (cfg_wr_en) begin
      station_address_r <= cfg_wr_data;
    end
  end

  assign in_beat.data_byte   = in_data_byte;
  assign in_beat.frame_start = in_frame_start;
  assign fire                = beat_valid && slot_free;

  mcfc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .take       (fire),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mcfc_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .beat            (beat),
    .station_address (station_address_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  mcfc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_command      = out_res.command;
  assign out_sequence_res = out_res.sequence_res;
  assign out_frame_length = out_res.frame_length;
  assign out_computed_crc = out_res.computed_crc;

endmodule

[rtl/mcfc_checker.sv]
`timescale 1ns / 1ps

module mcfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_command,
  input logic [7:0]  out_sequence_res,
  input logic [7:0]  out_frame_length,
  input logic [15:0] out_computed_crc
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_command)
      && $stable(out_sequence_res) && $stable(out_frame_length) && $stable(out_computed_crc))
    else $error("result beat changed under stall");

  // short frame result carries zeroed fields
  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mcfc_pkg::ST_LEN |->
      out_frame_length < mcfc_pkg::MIN_LENGTH && out_command == 8'd0
      && out_sequence_res == 8'd0 && out_computed_crc == 16'd0)
    else $error("length error beat with bad fields");

  // only address, sign or length errors may report a short frame
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_length < mcfc_pkg::MIN_LENGTH |->
      out_status == mcfc_pkg::ST_LEN || out_status == mcfc_pkg::ST_ADDR
      || out_status == mcfc_pkg::ST_SIGN)
    else $error("short frame with wrong status");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind modbus_crc_frame_checker mcfc_checker u_mcfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_command      (out_command),
  .out_sequence_res (out_sequence_res),
  .out_frame_length (out_frame_length),
  .out_computed_crc (out_computed_crc)
);
